>>> rtl/core/fqs_pkg.sv
// ----------------------------------------------------------------------------
// Feedback queue scheduler package
// Shared widths, opcodes, reset values and result field positions.
// ----------------------------------------------------------------------------
`default_nettype none

package fqs_pkg;

  // Field widths fixed by the item format
  localparam int SLOT_W  = 4;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 4;

  // Stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 112;

  // Input item kinds
  localparam logic OPC_ARRIVAL = 1'b0;
  localparam logic OPC_TICK    = 1'b1;

  // Deepest level after reset
  localparam logic [CFG_W-1:0] MAX_LEVEL_RST = 4'd8;

  // Result item field positions in m_tdata
  localparam int OUT_TIME_LSB   = 0;
  localparam int OUT_RUN_VLD    = 32;
  localparam int OUT_RUN_SLOT   = 33;
  localparam int OUT_DONE_VLD   = 37;
  localparam int OUT_DONE_SLOT  = 38;
  localparam int OUT_DONE_END   = 42;
  localparam int OUT_DONE_TURN  = 74;
  localparam int OUT_USED_W     = 106;

endpackage : fqs_pkg

`default_nettype wire

>>> rtl/core/feedback_queue_scheduler.sv
// ----------------------------------------------------------------------------
// Feedback queue scheduler
// Tick-driven multilevel feedback scheduler with per-level job queues.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) carries arrivals and ticks: s_tuser is the opcode,
//   s_tdata holds job_slot and burst_length. An arrival gives no result item;
//   every tick gives exactly one result item on the master stream (m_*).
//   cfg_we_i/cfg_wdata_i write max_level; write it only while idle.
// Sequencing:
//   The block takes one item at a time; s_tready is high only when idle.
//   An arrival passes ST_ARR and ST_PUSH (only ST_ARR when dropped for a
//   zero burst). A tick passes ST_TICK, ST_CUR and ST_OUT when the running
//   job keeps its quantum, adding ST_DEC, ST_PUSH, ST_DISP and ST_DISPW
//   when a job is demoted, requeued and another dispatched. The path is set
//   by the registered-read job table and queue RAMs, one access per cycle.
// Reset:
//   All queues empty, CPU idle, tick counter zero, max_level 8. The RAMs are
//   not cleared; an entry never written never reaches a result item.
// Stall:
//   A result item holds on m_tdata until m_tready; no new item is taken
//   and the tick counter does not advance meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module feedback_queue_scheduler #(
  parameter int MAX_JOBS = 16,
  parameter int LEVELS   = 9
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave stream
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  // [3:0] job_slot, [19:4] burst_length, [23:20] zero
  input  logic [fqs_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  // [0] opcode
  input  logic [fqs_pkg::IN_TUSER_W-1:0]   s_tuser_i,
  // master stream
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  // [31:0] tick_time, [32] running_valid, [36:33] running_slot,
  // [37] done_valid, [41:38] done_slot, [73:42] done_end_time,
  // [105:74] done_turnaround, [111:106] zero
  output logic [fqs_pkg::OUT_TDATA_W-1:0]  m_tdata_o,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [fqs_pkg::CFG_W-1:0]        cfg_wdata_i
);

  import fqs_pkg::*;

  localparam int LVL_W = $clog2(LEVELS);
  localparam int PTR_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int QNT_W = LEVELS;
  localparam int JA_W  = $clog2(MAX_JOBS);
  localparam int FA_W  = $clog2(LEVELS * MAX_JOBS);
  // job table word: {arrival, level, remaining}
  localparam int JW      = TIME_W + LVL_W + BURST_W;
  localparam int J_LVL   = BURST_W;
  localparam int J_ARR   = BURST_W + LVL_W;

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ARR   = 4'd1;
  localparam logic [3:0] ST_PUSH  = 4'd2;
  localparam logic [3:0] ST_TICK  = 4'd3;
  localparam logic [3:0] ST_CUR   = 4'd4;
  localparam logic [3:0] ST_DEC   = 4'd5;
  localparam logic [3:0] ST_DISP  = 4'd6;
  localparam logic [3:0] ST_DISPW = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [BURST_W-1:0] burst_q, burst_d;
  logic [CFG_W-1:0]   max_level_q, max_level_d;
  logic               busy_q, busy_d;
  logic [SLOT_W-1:0]  cpu_slot_q, cpu_slot_d;
  logic [QNT_W-1:0]   quantum_q, quantum_d;
  logic [TIME_W-1:0]  tick_q, tick_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic               have_next_q, have_next_d;
  logic [SLOT_W-1:0]  next_slot_q, next_slot_d;
  logic [BURST_W-1:0] cur_rem_q, cur_rem_d;
  logic [LVL_W-1:0]   cur_lvl_q, cur_lvl_d;
  logic [TIME_W-1:0]  cur_arr_q, cur_arr_d;
  logic [SLOT_W-1:0]  push_slot_q, push_slot_d;
  logic               ret_disp_q, ret_disp_d;
  logic               ran_q, ran_d;
  logic               done_q, done_d;
  logic [SLOT_W-1:0]  done_slot_q, done_slot_d;
  logic [TIME_W-1:0]  done_end_q, done_end_d;
  logic [TIME_W-1:0]  done_turn_q, done_turn_d;

  logic [PTR_W-1:0]   head_q [LEVELS];
  logic [PTR_W-1:0]   head_d [LEVELS];
  logic [PTR_W-1:0]   tail_q [LEVELS];
  logic [PTR_W-1:0]   tail_d [LEVELS];
  logic [CNT_W-1:0]   cnt_q  [LEVELS];
  logic [CNT_W-1:0]   cnt_d  [LEVELS];

  // RAM ports
  logic               job_we, job_re;
  logic [JA_W-1:0]    job_waddr, job_raddr;
  logic [JW-1:0]      job_wdata, job_rdata;
  logic               fifo_we, fifo_re;
  logic [FA_W-1:0]    fifo_waddr, fifo_raddr;
  logic [SLOT_W-1:0]  fifo_rdata;

  // shared service unit
  logic [BURST_W-1:0] unit_rem_in, unit_rem_out;
  logic [QNT_W-1:0]   unit_qnt_in, unit_qnt_out;
  logic [LVL_W-1:0]   unit_lvl;
  logic               unit_fresh;

  logic [LVL_W-1:0]   pop_lvl;
  logic               any_waiting;
  logic [CFG_W-1:0]   lvl_cap;
  logic [LVL_W-1:0]   demote_lvl;
  logic [PTR_W-1:0]   head_cur, tail_cur;
  logic [CNT_W-1:0]   cnt_cur;
  logic               s_accept;

  fqs_ram #(
    .WIDTH (JW),
    .DEPTH (MAX_JOBS)
  ) u_job_ram (
    .clk_i   (clk_i),
    .we_i    (job_we),
    .waddr_i (job_waddr),
    .wdata_i (job_wdata),
    .re_i    (job_re),
    .raddr_i (job_raddr),
    .rdata_o (job_rdata)
  );

  fqs_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (LEVELS * MAX_JOBS)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (push_slot_q),
    .re_i    (fifo_re),
    .raddr_i (fifo_raddr),
    .rdata_o (fifo_rdata)
  );

  assign s_tready_o = (state_q == ST_IDLE);
  assign s_accept   = s_tvalid_i & s_tready_o;
  assign m_tvalid_o = (state_q == ST_OUT);

  assign m_tdata_o = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                      done_turn_q, done_end_q, done_slot_q, done_q,
                      (ran_q ? cpu_slot_q : {SLOT_W{1'b0}}), ran_q, tick_q};

  // Highest non-empty level is the lowest index with entries
  always_comb begin
    pop_lvl     = '0;
    any_waiting = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        pop_lvl     = LVL_W'(i);
        any_waiting = 1'b1;
      end
    end
  end

  // Queue bookkeeping for the level under lvl_q
  assign head_cur = head_q[lvl_q];
  assign tail_cur = tail_q[lvl_q];
  assign cnt_cur  = cnt_q[lvl_q];

  assign fifo_raddr = FA_W'(lvl_q) * FA_W'(MAX_JOBS) + FA_W'(head_cur);
  assign fifo_waddr = FA_W'(lvl_q) * FA_W'(MAX_JOBS) + FA_W'(tail_cur);

  // Demotion ceiling: the lower of max_level and the deepest level
  assign lvl_cap    = (max_level_q > CFG_W'(LEVELS - 1)) ? CFG_W'(LEVELS - 1) : max_level_q;
  assign demote_lvl = (CFG_W'(cur_lvl_q) < lvl_cap) ? cur_lvl_q + LVL_W'(1) : cur_lvl_q;

  // One service unit: run a single unit of the selected job, with either the
  // live quantum or a fresh one of 2^level
  always_comb begin
    unit_rem_in = job_rdata[BURST_W-1:0];
    unit_lvl    = job_rdata[J_LVL +: LVL_W];
    unit_fresh  = 1'b1;
    unique case (state_q)
      ST_CUR: begin
        unit_fresh = 1'b0;
      end
      ST_DEC: begin
        unit_rem_in = cur_rem_q;
        unit_lvl    = cur_lvl_q;
      end
      default: begin
      end
    endcase
    unit_qnt_in  = unit_fresh ? (QNT_W'(1) << unit_lvl) : quantum_q;
    unit_rem_out = (unit_rem_in != '0) ? unit_rem_in - BURST_W'(1) : unit_rem_in;
    if (unit_rem_out == '0) begin
      unit_qnt_out = '0;
    end else if (unit_qnt_in != '0) begin
      unit_qnt_out = unit_qnt_in - QNT_W'(1);
    end else begin
      unit_qnt_out = unit_qnt_in;
    end
  end

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    burst_d     = burst_q;
    max_level_d = cfg_we_i ? cfg_wdata_i : max_level_q;
    busy_d      = busy_q;
    cpu_slot_d  = cpu_slot_q;
    quantum_d   = quantum_q;
    tick_d      = tick_q;
    lvl_d       = lvl_q;
    have_next_d = have_next_q;
    next_slot_d = next_slot_q;
    cur_rem_d   = cur_rem_q;
    cur_lvl_d   = cur_lvl_q;
    cur_arr_d   = cur_arr_q;
    push_slot_d = push_slot_q;
    ret_disp_d  = ret_disp_q;
    ran_d       = ran_q;
    done_d      = done_q;
    done_slot_d = done_slot_q;
    done_end_d  = done_end_q;
    done_turn_d = done_turn_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;

    job_we    = 1'b0;
    job_re    = 1'b0;
    job_waddr = JA_W'(cpu_slot_q);
    job_raddr = JA_W'(cpu_slot_q);
    job_wdata = {job_rdata[J_ARR +: TIME_W], job_rdata[J_LVL +: LVL_W], unit_rem_out};
    fifo_we   = 1'b0;
    fifo_re   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          slot_d  = s_tdata_i[SLOT_W-1:0];
          burst_d = s_tdata_i[SLOT_W +: BURST_W];
          state_d = (s_tuser_i[0] == OPC_ARRIVAL) ? ST_ARR : ST_TICK;
        end
      end

      ST_ARR: begin
        // drop zero bursts and slots beyond the table
        if (burst_q == '0 || 32'(slot_q) >= MAX_JOBS) begin
          state_d = ST_IDLE;
        end else begin
          job_we      = 1'b1;
          job_waddr   = JA_W'(slot_q);
          job_wdata   = {tick_q, {LVL_W{1'b0}}, burst_q};
          lvl_d       = '0;
          push_slot_d = slot_q;
          ret_disp_d  = 1'b0;
          state_d     = ST_PUSH;
        end
      end

      ST_PUSH: begin
        // a push into a full level is dropped
        if (cnt_cur < CNT_W'(MAX_JOBS)) begin
          fifo_we       = 1'b1;
          tail_d[lvl_q] = (tail_cur == PTR_W'(MAX_JOBS - 1)) ? '0 : tail_cur + PTR_W'(1);
          cnt_d[lvl_q]  = cnt_cur + CNT_W'(1);
        end
        state_d = ret_disp_q ? ST_DISP : ST_IDLE;
      end

      ST_TICK: begin
        ran_d       = 1'b0;
        done_d      = 1'b0;
        done_slot_d = '0;
        done_end_d  = '0;
        done_turn_d = '0;
        lvl_d       = pop_lvl;
        have_next_d = any_waiting;
        job_re      = 1'b1;
        state_d     = ST_CUR;
      end

      ST_CUR: begin
        cur_rem_d = job_rdata[BURST_W-1:0];
        cur_lvl_d = job_rdata[J_LVL +: LVL_W];
        cur_arr_d = job_rdata[J_ARR +: TIME_W];
        if (busy_q && quantum_q != '0) begin
          // keep running the current job
          job_we    = 1'b1;
          quantum_d = unit_qnt_out;
          ran_d     = 1'b1;
          state_d   = ST_OUT;
        end else begin
          if (have_next_q) begin
            fifo_re       = 1'b1;
            head_d[lvl_q] = (head_cur == PTR_W'(MAX_JOBS - 1)) ? '0 : head_cur + PTR_W'(1);
            cnt_d[lvl_q]  = cnt_cur - CNT_W'(1);
          end
          state_d = ST_DEC;
        end
      end

      ST_DEC: begin
        next_slot_d = fifo_rdata;
        if (!busy_q) begin
          quantum_d = '0;
          state_d   = have_next_q ? ST_DISP : ST_OUT;
        end else if (cur_rem_q == '0) begin
          // report completion, free the CPU
          done_d      = 1'b1;
          done_slot_d = cpu_slot_q;
          done_end_d  = tick_q;
          done_turn_d = tick_q - cur_arr_q;
          busy_d      = 1'b0;
          cpu_slot_d  = '0;
          quantum_d   = '0;
          state_d     = have_next_q ? ST_DISP : ST_OUT;
        end else if (!have_next_q) begin
          // nothing waits: fresh quantum for the same job
          job_we    = 1'b1;
          job_wdata = {cur_arr_q, cur_lvl_q, unit_rem_out};
          quantum_d = unit_qnt_out;
          ran_d     = 1'b1;
          state_d   = ST_OUT;
        end else begin
          // demote and requeue behind the waiting jobs
          job_we      = 1'b1;
          job_wdata   = {cur_arr_q, demote_lvl, cur_rem_q};
          lvl_d       = demote_lvl;
          push_slot_d = cpu_slot_q;
          ret_disp_d  = 1'b1;
          state_d     = ST_PUSH;
        end
      end

      ST_DISP: begin
        busy_d     = 1'b1;
        cpu_slot_d = next_slot_q;
        job_re     = 1'b1;
        job_raddr  = JA_W'(next_slot_q);
        state_d    = ST_DISPW;
      end

      ST_DISPW: begin
        job_we    = 1'b1;
        quantum_d = unit_qnt_out;
        ran_d     = 1'b1;
        state_d   = ST_OUT;
      end

      ST_OUT: begin
        if (m_tready_i) begin
          tick_d  = tick_q + TIME_W'(1);
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_level_q <= MAX_LEVEL_RST;
      busy_q      <= 1'b0;
      cpu_slot_q  <= '0;
      quantum_q   <= '0;
      tick_q      <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      max_level_q <= max_level_d;
      busy_q      <= busy_d;
      cpu_slot_q  <= cpu_slot_d;
      quantum_q   <= quantum_d;
      tick_q      <= tick_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    burst_q     <= burst_d;
    lvl_q       <= lvl_d;
    have_next_q <= have_next_d;
    next_slot_q <= next_slot_d;
    cur_rem_q   <= cur_rem_d;
    cur_lvl_q   <= cur_lvl_d;
    cur_arr_q   <= cur_arr_d;
    push_slot_q <= push_slot_d;
    ret_disp_q  <= ret_disp_d;
    ran_q       <= ran_d;
    done_q      <= done_d;
    done_slot_q <= done_slot_d;
    done_end_q  <= done_end_d;
    done_turn_q <= done_turn_d;
  end

endmodule : feedback_queue_scheduler

`default_nettype wire

>>> rtl/core/fqs_ram.sv
// ----------------------------------------------------------------------------
// Feedback queue scheduler RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : fqs_ram

`default_nettype wire

>>> rtl/core/fqs_checker.sv
// ----------------------------------------------------------------------------
// Feedback queue scheduler checker
// Port-level assertions, bound to the scheduler top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fqs_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_o,
  input  logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  input  logic [fqs_pkg::OUT_TDATA_W-1:0]  m_tdata_o
);

  import fqs_pkg::*;

  // one item at a time: never ready while a result waits
  a_no_accept_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> !s_tready_o)
    else $error("input ready while a result item is pending");

  // a result never appears the cycle after an item is taken
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !m_tvalid_o)
    else $error("result item too early after input acceptance");

  // a stalled result holds
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> (m_tvalid_o && $stable(m_tdata_o)))
    else $error("stalled result item changed");

  // no running job means a zero running slot
  a_idle_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tdata_o[OUT_RUN_VLD]) |->
      (m_tdata_o[OUT_RUN_SLOT +: SLOT_W] == '0))
    else $error("running slot set without a running job");

  // completion is stamped with the tick it is reported on
  a_done_end_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tdata_o[OUT_DONE_VLD]) |->
      (m_tdata_o[OUT_DONE_END +: TIME_W] == m_tdata_o[OUT_TIME_LSB +: TIME_W]))
    else $error("completion end time differs from tick time");

endmodule : fqs_checker

bind feedback_queue_scheduler fqs_checker u_fqs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .s_tvalid_i  (s_tvalid_i),
  .s_tready_o  (s_tready_o),
  .m_tvalid_o  (m_tvalid_o),
  .m_tready_i  (m_tready_i),
  .m_tdata_o   (m_tdata_o)
);

`default_nettype wire
